@@ rtl/core/cau_pkg.sv @@
package cau_pkg;

	localparam int WORD_BITS    = 32;
	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;

	// division: two extra quotient bits for overflow and rounding
	localparam int QUO_BITS = WORD_BITS + 2;
	localparam int DVD_BITS = PROD_BITS + FRAC_BITS + 1;

	// cordic datapath
	localparam int GUARD       = 60 - WORD_BITS;
	localparam int ANG_BITS    = 30;
	localparam int CORDIC_BITS = 64;
	localparam int Z_BITS      = ANG_BITS + 6;
	localparam int GAIN_BITS   = 30;
	localparam int LO_BITS     = 32;
	localparam int HI_BITS     = CORDIC_BITS - 1 - LO_BITS;
	localparam int PPL_BITS    = LO_BITS + GAIN_BITS;
	localparam int PPH_BITS    = HI_BITS + GAIN_BITS;
	localparam int FULL_BITS   = PPH_BITS + LO_BITS + 1;
	localparam int MAG_SHIFT   = GUARD + ANG_BITS - FRAC_BITS;
	localparam int ANG_SHIFT   = ANG_BITS - FRAC_BITS;

	localparam logic signed [Z_BITS-1:0] PI_Q30 = 36'sd3373259426;

	// pipeline stage where each result is ready
	localparam int ST_ADDSUB = 2;
	localparam int ST_MUL    = 5;
	localparam int ST_DINIT  = 5;
	localparam int ST_CORD   = 2 + CORDIC_STEPS;
	localparam int ST_POLAR  = ST_CORD + 2;
	localparam int ST_DIV    = ST_DINIT + QUO_BITS + 1;
	localparam int LATENCY   = ST_DIV + 1;

	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_SUB   = 3'd1;
	localparam logic [2:0] ACT_MUL   = 3'd2;
	localparam logic [2:0] ACT_DIV   = 3'd3;
	localparam logic [2:0] ACT_POLAR = 3'd4;

	typedef struct packed {
		logic [2:0]                  action;
		logic signed [WORD_BITS-1:0] a_re;
		logic signed [WORD_BITS-1:0] a_im;
		logic signed [WORD_BITS-1:0] b_re;
		logic signed [WORD_BITS-1:0] b_im;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] res_re;
		logic signed [WORD_BITS-1:0] res_im;
		logic                        divide_by_zero;
		logic                        saturated;
	} rsp_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic [ANG_BITS-1:0] atan_q30(input int i);
		logic [ANG_BITS-1:0] v;
		case (i)
			0:  v = 30'h3243F6A8;
			1:  v = 30'h1DAC6705;
			2:  v = 30'h0FADBAFC;
			3:  v = 30'h07F56EA6;
			4:  v = 30'h03FEAB76;
			5:  v = 30'h01FFD55B;
			6:  v = 30'h00FFFAAA;
			7:  v = 30'h007FFF55;
			8:  v = 30'h003FFFEA;
			9:  v = 30'h001FFFFD;
			10: v = 30'h000FFFFF;
			11: v = 30'h0007FFFF;
			12: v = 30'h0003FFFF;
			13: v = 30'h0001FFFF;
			14: v = 30'h0000FFFF;
			15: v = 30'h00007FFF;
			16: v = 30'h00003FFF;
			17: v = 30'h00001FFF;
			18: v = 30'h00000FFF;
			19: v = 30'h000007FF;
			20: v = 30'h000003FF;
			21: v = 30'h000001FF;
			22: v = 30'h000000FF;
			23: v = 30'h0000007F;
			24: v = 30'h0000003F;
			25: v = 30'h0000001F;
			26: v = 30'h0000000F;
			27: v = 30'h00000007;
			28: v = 30'h00000003;
			29: v = 30'h00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [63:0] isqrt_u64(input logic [63:0] g0);
		logic [63:0] g;
		logic [63:0] res;
		logic [63:0] bit_v;
		g     = g0;
		res   = '0;
		bit_v = 64'd1 << 62;
		for (int k = 0; k < 32; k++)
			if (bit_v > g)
				bit_v = bit_v >> 2;
		for (int k = 0; k < 32; k++) begin
			if (bit_v != 64'd0) begin
				if (g >= res + bit_v) begin
					g   = g - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
		end
		return res;
	endfunction

	// squared cordic gain in Q60
	function automatic logic [63:0] gain_sq();
		logic [63:0] g;
		g = 64'd1 << 60;
		for (int i = 0; i < 31; i++)
			if (i < CORDIC_STEPS)
				g = g + (g >> (2 * i));
		return g;
	endfunction

	localparam logic [63:0] INV_GAIN_W = (64'd1 << 60) / isqrt_u64(gain_sq());
	localparam logic [GAIN_BITS-1:0] INV_GAIN = INV_GAIN_W[GAIN_BITS-1:0];

	// clip sign-magnitude to WORD_BITS signed, msb of result is the clip flag
	function automatic logic [WORD_BITS:0] clip_sm(input logic neg,
			input logic [SUM_BITS-1:0] mag);
		logic [SUM_BITS-1:0]  lim;
		logic [SUM_BITS-1:0]  m;
		logic                 sat;
		logic [WORD_BITS-1:0] v;
		lim = (SUM_BITS'(1) << (WORD_BITS - 1)) - SUM_BITS'(!neg);
		sat = mag > lim;
		m   = sat ? lim : mag;
		v   = neg ? -m[WORD_BITS-1:0] : m[WORD_BITS-1:0];
		return {sat, v};
	endfunction

	function automatic logic [WORD_BITS:0] clip_s(input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-1:0] mag;
		mag = v[SUM_BITS-1] ? SUM_BITS'(-v) : SUM_BITS'(v);
		return clip_sm(v[SUM_BITS-1], mag);
	endfunction

endpackage

@@ rtl/core/complex_arithmetic_unit_core.sv @@
// complex add/sub/mul/div and polar conversion on signed fixed point
// result strobe done comes at the end of the pipeline (LATENCY, set by the 34-step
// pipelined divider plus operand and rounding stages)
// throughput: one transaction per cycle, busy stays low; the receiver cannot stall
// reset: arst_n clears the valid bits only, in-flight transactions are dropped
module complex_arithmetic_unit_core
	import cau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output rsp_t result,
	output logic done
);

	logic             vld_s [1:ST_DIV];
	logic [2:0]       act_s [1:ST_DIV];
	cmd_t             cmd_s1;
	logic             accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_DIV; k++)
				vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= accept;
			for (int k = 2; k <= ST_DIV; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= cmd;
		act_s[1] <= cmd.action;
		for (int k = 2; k <= ST_DIV; k++)
			act_s[k] <= act_s[k-1];
	end

	// add / subtract
	rsp_t                      as_s [ST_ADDSUB:ST_DIV];
	logic signed [SUM_BITS-1:0] as_re;
	logic signed [SUM_BITS-1:0] as_im;
	logic [WORD_BITS:0]        as_cre;
	logic [WORD_BITS:0]        as_cim;

	always_comb begin
		if (act_s[1] == ACT_SUB) begin
			as_re = SUM_BITS'(cmd_s1.a_re) - SUM_BITS'(cmd_s1.b_re);
			as_im = SUM_BITS'(cmd_s1.a_im) - SUM_BITS'(cmd_s1.b_im);
		end else begin
			as_re = SUM_BITS'(cmd_s1.a_re) + SUM_BITS'(cmd_s1.b_re);
			as_im = SUM_BITS'(cmd_s1.a_im) + SUM_BITS'(cmd_s1.b_im);
		end
		as_cre = clip_s(as_re);
		as_cim = clip_s(as_im);
	end

	always_ff @(posedge clk) begin
		as_s[ST_ADDSUB].res_re         <= as_cre[WORD_BITS-1:0];
		as_s[ST_ADDSUB].res_im         <= as_cim[WORD_BITS-1:0];
		as_s[ST_ADDSUB].divide_by_zero <= 1'b0;
		as_s[ST_ADDSUB].saturated      <= as_cre[WORD_BITS] | as_cim[WORD_BITS];
		for (int k = ST_ADDSUB + 1; k <= ST_DIV; k++)
			as_s[k] <= as_s[k-1];
	end

	// products for multiply and divide; all but cc and dd are shared by both
	logic signed [PROD_BITS-1:0] p_ac_s2, p_bd_s2, p_ad_s2, p_bc_s2, p_cc_s2, p_dd_s2;

	always_ff @(posedge clk) begin
		p_ac_s2 <= PROD_BITS'(cmd_s1.a_re) * PROD_BITS'(cmd_s1.b_re);
		p_bd_s2 <= PROD_BITS'(cmd_s1.a_im) * PROD_BITS'(cmd_s1.b_im);
		p_ad_s2 <= PROD_BITS'(cmd_s1.a_re) * PROD_BITS'(cmd_s1.b_im);
		p_bc_s2 <= PROD_BITS'(cmd_s1.a_im) * PROD_BITS'(cmd_s1.b_re);
		p_cc_s2 <= PROD_BITS'(cmd_s1.b_re) * PROD_BITS'(cmd_s1.b_re);
		p_dd_s2 <= PROD_BITS'(cmd_s1.b_im) * PROD_BITS'(cmd_s1.b_im);
	end

	logic signed [SUM_BITS-1:0] m_re_s3, m_im_s3, d_re_s3, d_im_s3, den_s3;

	always_ff @(posedge clk) begin
		m_re_s3 <= SUM_BITS'(p_ac_s2) - SUM_BITS'(p_bd_s2);
		m_im_s3 <= SUM_BITS'(p_ad_s2) + SUM_BITS'(p_bc_s2);
		d_re_s3 <= SUM_BITS'(p_ac_s2) + SUM_BITS'(p_bd_s2);
		d_im_s3 <= SUM_BITS'(p_bc_s2) - SUM_BITS'(p_ad_s2);
		den_s3  <= SUM_BITS'(p_cc_s2) + SUM_BITS'(p_dd_s2);
	end

	logic                 mneg_re_s4, mneg_im_s4, dneg_re_s4, dneg_im_s4, dz_s4;
	logic [PROD_BITS-1:0] mmag_re_s4, mmag_im_s4, dmag_re_s4, dmag_im_s4, den_s4;

	always_ff @(posedge clk) begin
		mneg_re_s4 <= m_re_s3[SUM_BITS-1];
		mneg_im_s4 <= m_im_s3[SUM_BITS-1];
		dneg_re_s4 <= d_re_s3[SUM_BITS-1];
		dneg_im_s4 <= d_im_s3[SUM_BITS-1];
		mmag_re_s4 <= PROD_BITS'(m_re_s3[SUM_BITS-1] ? -m_re_s3 : m_re_s3);
		mmag_im_s4 <= PROD_BITS'(m_im_s3[SUM_BITS-1] ? -m_im_s3 : m_im_s3);
		dmag_re_s4 <= PROD_BITS'(d_re_s3[SUM_BITS-1] ? -d_re_s3 : d_re_s3);
		dmag_im_s4 <= PROD_BITS'(d_im_s3[SUM_BITS-1] ? -d_im_s3 : d_im_s3);
		den_s4     <= den_s3[PROD_BITS-1:0];
		dz_s4      <= den_s3 == '0;
	end

	// multiply result, round half away from zero on the magnitude
	rsp_t               mul_s [ST_MUL:ST_DIV];
	logic [WORD_BITS:0] mul_cre, mul_cim;

	always_comb begin
		mul_cre = clip_sm(mneg_re_s4,
			(SUM_BITS'(mmag_re_s4) + (SUM_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
		mul_cim = clip_sm(mneg_im_s4,
			(SUM_BITS'(mmag_im_s4) + (SUM_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		mul_s[ST_MUL].res_re         <= mul_cre[WORD_BITS-1:0];
		mul_s[ST_MUL].res_im         <= mul_cim[WORD_BITS-1:0];
		mul_s[ST_MUL].divide_by_zero <= 1'b0;
		mul_s[ST_MUL].saturated      <= mul_cre[WORD_BITS] | mul_cim[WORD_BITS];
		for (int k = ST_MUL + 1; k <= ST_DIV; k++)
			mul_s[k] <= mul_s[k-1];
	end

	// restoring divider, one quotient bit per stage, two lanes sharing the divisor
	localparam int ST_DLAST = ST_DINIT + QUO_BITS;

	logic [PROD_BITS-1:0] drem_s [0:1][ST_DINIT:ST_DLAST];
	logic [QUO_BITS-1:0]  dq_s   [0:1][ST_DINIT:ST_DLAST];
	logic [PROD_BITS-1:0] dmag_s [0:1][ST_DINIT:ST_DLAST];
	logic                 dovf_s [0:1][ST_DINIT:ST_DLAST];
	logic                 dneg_s [0:1][ST_DINIT:ST_DLAST];
	logic [PROD_BITS-1:0] dden_s [ST_DINIT:ST_DLAST];
	logic                 ddz_s  [ST_DINIT:ST_DLAST];

	logic [PROD_BITS-1:0] dmag_in [0:1];
	logic                 dneg_in [0:1];

	assign dmag_in[0] = dmag_re_s4;
	assign dmag_in[1] = dmag_im_s4;
	assign dneg_in[0] = dneg_re_s4;
	assign dneg_in[1] = dneg_im_s4;

	always_ff @(posedge clk) begin
		dden_s[ST_DINIT] <= den_s4;
		ddz_s[ST_DINIT]  <= dz_s4;
		for (int k = ST_DINIT + 1; k <= ST_DLAST; k++) begin
			dden_s[k] <= dden_s[k-1];
			ddz_s[k]  <= ddz_s[k-1];
		end
	end

	for (genvar ln = 0; ln < 2; ln++) begin : g_lane
		logic [DVD_BITS-1:0] dvd;
		logic [PROD_BITS-1:0] rem0;

		assign dvd  = {dmag_in[ln], {(FRAC_BITS + 1){1'b0}}};
		assign rem0 = PROD_BITS'(dvd >> QUO_BITS);

		always_ff @(posedge clk) begin
			drem_s[ln][ST_DINIT] <= rem0;
			dovf_s[ln][ST_DINIT] <= rem0 >= den_s4;
			dq_s[ln][ST_DINIT]   <= '0;
			dmag_s[ln][ST_DINIT] <= dmag_in[ln];
			dneg_s[ln][ST_DINIT] <= dneg_in[ln];
		end

		for (genvar j = 1; j <= QUO_BITS; j++) begin : g_step
			localparam int IDX = QUO_BITS - j;
			localparam int ST  = ST_DINIT + j;
			logic                 nb;
			logic [PROD_BITS:0]   rs;
			logic                 ge;

			if (IDX >= FRAC_BITS + 1) begin : g_bit
				assign nb = dmag_s[ln][ST-1][IDX-FRAC_BITS-1];
			end else begin : g_zero
				assign nb = 1'b0;
			end

			assign rs = {drem_s[ln][ST-1], nb};
			assign ge = rs >= {1'b0, dden_s[ST-1]};

			always_ff @(posedge clk) begin
				drem_s[ln][ST] <= ge ? PROD_BITS'(rs - {1'b0, dden_s[ST-1]})
				                     : rs[PROD_BITS-1:0];
				dq_s[ln][ST]   <= {dq_s[ln][ST-1][QUO_BITS-2:0], ge};
				dmag_s[ln][ST] <= dmag_s[ln][ST-1];
				dovf_s[ln][ST] <= dovf_s[ln][ST-1];
				dneg_s[ln][ST] <= dneg_s[ln][ST-1];
			end
		end
	end

	rsp_t               div_s;
	logic [WORD_BITS:0] div_c [0:1];

	always_comb begin
		for (int ln = 0; ln < 2; ln++) begin
			if (dovf_s[ln][ST_DLAST])
				div_c[ln] = clip_sm(dneg_s[ln][ST_DLAST], '1);
			else
				div_c[ln] = clip_sm(dneg_s[ln][ST_DLAST],
					SUM_BITS'((SUM_BITS'(dq_s[ln][ST_DLAST]) + SUM_BITS'(1)) >> 1));
		end
	end

	always_ff @(posedge clk) begin
		if (ddz_s[ST_DLAST]) begin
			div_s <= '{res_re: '0, res_im: '0, divide_by_zero: 1'b1, saturated: 1'b0};
		end else begin
			div_s.res_re         <= div_c[0][WORD_BITS-1:0];
			div_s.res_im         <= div_c[1][WORD_BITS-1:0];
			div_s.divide_by_zero <= 1'b0;
			div_s.saturated      <= div_c[0][WORD_BITS] | div_c[1][WORD_BITS];
		end
	end

	// vectoring cordic, one micro-rotation per stage
	logic signed [CORDIC_BITS-1:0] cx_s [2:ST_CORD];
	logic signed [CORDIC_BITS-1:0] cy_s [2:ST_CORD];
	logic signed [Z_BITS-1:0]      cz_s [2:ST_CORD];
	logic                          cnul_s [2:ST_POLAR-1];

	logic                      p_neg;
	logic signed [WORD_BITS:0] p_x, p_y;

	always_comb begin
		p_neg = cmd_s1.a_re[WORD_BITS-1];
		p_x   = p_neg ? -(WORD_BITS + 1)'(cmd_s1.a_re) : (WORD_BITS + 1)'(cmd_s1.a_re);
		p_y   = p_neg ? -(WORD_BITS + 1)'(cmd_s1.a_im) : (WORD_BITS + 1)'(cmd_s1.a_im);
	end

	always_ff @(posedge clk) begin
		cx_s[2]   <= CORDIC_BITS'(p_x) <<< GUARD;
		cy_s[2]   <= CORDIC_BITS'(p_y) <<< GUARD;
		cz_s[2]   <= !p_neg ? '0 : (cmd_s1.a_im[WORD_BITS-1] ? -PI_Q30 : PI_Q30);
		cnul_s[2] <= cmd_s1.a_re == '0 && cmd_s1.a_im == '0;
		for (int k = 3; k < ST_POLAR; k++)
			cnul_s[k] <= cnul_s[k-1];
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		localparam logic signed [Z_BITS-1:0] ATAN = Z_BITS'(atan_q30(i));

		always_ff @(posedge clk) begin
			if (!cy_s[2+i][CORDIC_BITS-1]) begin
				cx_s[3+i] <= cx_s[2+i] + (cy_s[2+i] >>> i);
				cy_s[3+i] <= cy_s[2+i] - (cx_s[2+i] >>> i);
				cz_s[3+i] <= cz_s[2+i] + ATAN;
			end else begin
				cx_s[3+i] <= cx_s[2+i] - (cy_s[2+i] >>> i);
				cy_s[3+i] <= cy_s[2+i] + (cx_s[2+i] >>> i);
				cz_s[3+i] <= cz_s[2+i] - ATAN;
			end
		end
	end

	// gain removal split into two partial products, x stays non-negative
	logic [PPL_BITS-1:0]        ppl_s;
	logic [PPH_BITS-1:0]        pph_s;
	logic signed [Z_BITS-1:0]   pang_s;

	always_ff @(posedge clk) begin
		ppl_s  <= PPL_BITS'(cx_s[ST_CORD][LO_BITS-1:0]) * PPL_BITS'(INV_GAIN);
		pph_s  <= PPH_BITS'(cx_s[ST_CORD][CORDIC_BITS-2:LO_BITS]) * PPH_BITS'(INV_GAIN);
		pang_s <= (cz_s[ST_CORD] + (Z_BITS'(1) <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
	end

	rsp_t               pol_s [ST_POLAR:ST_DIV];
	logic [FULL_BITS-1:0] pfull;
	logic [WORD_BITS:0] pol_cm, pol_ca;

	always_comb begin
		pfull = (FULL_BITS'(pph_s) << LO_BITS) + FULL_BITS'(ppl_s)
		      + (FULL_BITS'(1) << (MAG_SHIFT - 1));
		pol_cm = clip_sm(1'b0, SUM_BITS'(pfull >> MAG_SHIFT));
		pol_ca = clip_s(SUM_BITS'(pang_s));
	end

	always_ff @(posedge clk) begin
		if (cnul_s[ST_POLAR-1]) begin
			pol_s[ST_POLAR] <= '0;
		end else begin
			pol_s[ST_POLAR].res_re         <= pol_cm[WORD_BITS-1:0];
			pol_s[ST_POLAR].res_im         <= pol_ca[WORD_BITS-1:0];
			pol_s[ST_POLAR].divide_by_zero <= 1'b0;
			pol_s[ST_POLAR].saturated      <= pol_cm[WORD_BITS] | pol_ca[WORD_BITS];
		end
		for (int k = ST_POLAR + 1; k <= ST_DIV; k++)
			pol_s[k] <= pol_s[k-1];
	end

	// output register
	rsp_t result_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_s[ST_DIV];
	end

	always_ff @(posedge clk) begin
		case (act_s[ST_DIV])
			ACT_ADD, ACT_SUB: result_q <= as_s[ST_DIV];
			ACT_MUL:          result_q <= mul_s[ST_DIV];
			ACT_DIV:          result_q <= div_s;
			ACT_POLAR:        result_q <= pol_s[ST_DIV];
			default:          result_q <= '0;
		endcase
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

@@ rtl/core/cau_checker.sv @@
module cau_checker
	import cau_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input rsp_t result,
	input logic done
);

	// every accepted transaction comes back after a fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted transaction gave no result");

	// no result without a transaction behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a transaction");

	// zero divisor only on divide, with zeroed parts
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |->
			$past(cmd.action, LATENCY) == ACT_DIV && result.res_re == '0 &&
			result.res_im == '0 && !result.saturated)
		else $error("bad divide by zero result");

	// unknown actions give an all-zero result
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action > ACT_POLAR |-> ##LATENCY
			(result.res_re == '0 && result.res_im == '0 &&
			!result.divide_by_zero && !result.saturated))
		else $error("unknown action gave a result");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (.*);

@@ tb/complex_arithmetic_unit_checker.sv @@
`timescale 1ns / 1ps

module complex_arithmetic_unit_checker
	import cau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  rsp_t result,
	input  logic done,
	output int   fails,
	output int   pending
);

	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

	// atan(2^-i) in Q30 radians, truncated
	localparam logic [29:0] ATAN_TAB [16] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
		30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
		30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
		30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF
	};

	rsp_t        expected_results[$];
	logic [63:0] recip_gain;

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0]  r;
		logic [127:0] t;
		r = '0;
		for (int k = 31; k >= 0; k--) begin
			t = 128'(r | (64'd1 << k));
			if (t * t <= 128'(v))
				r = r | (64'd1 << k);
		end
		return r;
	endfunction

	function automatic logic [63:0] cordic_recip_gain();
		logic [63:0] g;
		g = ONE_Q60;
		for (int i = 0; i < CORDIC_STEPS; i++)
			g = g + (g >> (2 * i));
		return ONE_Q60 / floor_sqrt(g);
	endfunction

	// clip sign and magnitude to a 32-bit signed word
	function automatic logic [31:0] clip_word(input logic neg, input logic [127:0] mag,
			inout logic sat);
		logic [127:0] lim;
		lim = (128'd1 << 31) - (neg ? 128'd0 : 128'd1);
		if (mag > lim) begin
			mag = lim;
			sat = 1'b1;
		end
		return neg ? -mag[31:0] : mag[31:0];
	endfunction

	function automatic logic [31:0] clip_signed(input logic signed [127:0] v, inout logic sat);
		return clip_word(v < 0, v < 0 ? 128'(-v) : 128'(v), sat);
	endfunction

	function automatic logic [127:0] abs128(input logic signed [127:0] v);
		return v < 0 ? 128'(-v) : 128'(v);
	endfunction

	// rounded num * 2^16 / den, capped at 2^32
	function automatic logic [127:0] frac_quotient(input logic [127:0] num,
			input logic [127:0] den);
		logic [127:0] q;
		logic [127:0] r;
		q = (num << FRAC_BITS) / den;
		r = (num << FRAC_BITS) % den;
		if ((r << 1) >= den)
			q = q + 1;
		return q > (128'd1 << 32) ? (128'd1 << 32) : q;
	endfunction

	function automatic rsp_t predict_result(input cmd_t c);
		rsp_t                 r;
		logic signed [127:0]  a;
		logic signed [127:0]  b;
		logic signed [127:0]  x;
		logic signed [127:0]  y;
		logic signed [127:0]  pr;
		logic signed [127:0]  pi_;
		logic [127:0]         den;
		logic [127:0]         prod;
		longint               xs;
		longint               ys;
		longint               dx;
		longint               dy;
		longint               z;
		logic                 sat;
		r   = '0;
		sat = 1'b0;
		a   = c.a_re;
		b   = c.a_im;
		x   = c.b_re;
		y   = c.b_im;
		case (c.action)
			ACT_ADD: begin
				r.res_re = clip_signed(a + x, sat);
				r.res_im = clip_signed(b + y, sat);
			end
			ACT_SUB: begin
				r.res_re = clip_signed(a - x, sat);
				r.res_im = clip_signed(b - y, sat);
			end
			ACT_MUL: begin
				pr = a * x - b * y;
				pi_ = a * y + b * x;
				r.res_re = clip_word(pr < 0, (abs128(pr) + (128'd1 << (FRAC_BITS - 1)))
					>> FRAC_BITS, sat);
				r.res_im = clip_word(pi_ < 0, (abs128(pi_) + (128'd1 << (FRAC_BITS - 1)))
					>> FRAC_BITS, sat);
			end
			ACT_DIV: begin
				den = 128'(x * x + y * y);
				if (den == 0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					pr = a * x + b * y;
					pi_ = b * x - a * y;
					r.res_re = clip_word(pr < 0, frac_quotient(abs128(pr), den), sat);
					r.res_im = clip_word(pi_ < 0, frac_quotient(abs128(pi_), den), sat);
				end
			end
			ACT_POLAR: begin
				if (a != 0 || b != 0) begin
					z = 0;
					if (a < 0) begin
						z = b < 0 ? -longint'(PI_Q30) : longint'(PI_Q30);
						a = -a;
						b = -b;
					end
					xs = longint'(a) <<< GUARD;
					ys = longint'(b) <<< GUARD;
					for (int i = 0; i < CORDIC_STEPS; i++) begin
						dx = ys >>> i;
						dy = xs >>> i;
						if (ys >= 0) begin
							xs = xs + dx;
							ys = ys - dy;
							z  = z + longint'(ATAN_TAB[i]);
						end else begin
							xs = xs - dx;
							ys = ys + dy;
							z  = z - longint'(ATAN_TAB[i]);
						end
					end
					prod = abs128(xs) * 128'(recip_gain) + (128'd1 << (MAG_SHIFT - 1));
					r.res_re = clip_word(1'b0, prod >> MAG_SHIFT, sat);
					z = (z + (longint'(1) <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
					r.res_im = clip_signed(z, sat);
				end
			end
			default: ;
		endcase
		r.saturated = sat;
		return r;
	endfunction

	initial recip_gain = cordic_recip_gain();

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			fails <= 0;
			expected_results.delete();
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no transaction outstanding");
					fails <= fails + 1;
				end else begin
					want = expected_results.pop_front();
					if (result.res_re !== want.res_re)
						$error("res_re expected %0d actual %0d", want.res_re, result.res_re);
					if (result.res_im !== want.res_im)
						$error("res_im expected %0d actual %0d", want.res_im, result.res_im);
					if (result.divide_by_zero !== want.divide_by_zero)
						$error("divide_by_zero expected %0b actual %0b",
							want.divide_by_zero, result.divide_by_zero);
					if (result.saturated !== want.saturated)
						$error("saturated expected %0b actual %0b",
							want.saturated, result.saturated);
					if (result !== want)
						fails <= fails + 1;
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_result(cmd));
		end
	end

endmodule

@@ tb/complex_arithmetic_unit_core_tb.sv @@
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_tb;
	import cau_pkg::*;

	localparam int STALL_LIMIT = 4 * LATENCY + 400;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	rsp_t result;
	logic done;
	int   fails;
	int   pending;
	int   quiet_cycles;
	int   idle_pct;

	complex_arithmetic_unit_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.result (result),
		.done   (done)
	);

	complex_arithmetic_unit_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.result  (result),
		.done    (done),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles with no transaction in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("complex_arithmetic_unit_core_tb NOT OK");
			$finish;
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return '0;
			3, 4:    return $urandom();
			5:       return 32'(int'($urandom_range(0, 16'hFFFF)) - 32768);
			default: return 32'(int'($urandom_range(0, 24'hFF_FFFF)) - 24'h80_0000);
		endcase
	endfunction

	task automatic issue(input logic [2:0] act, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi);
		logic taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		cmd.action <= act;
		cmd.a_re   <= ar;
		cmd.a_im   <= ai;
		cmd.b_re   <= br;
		cmd.b_im   <= bi;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	initial begin
		logic [2:0]  act;
		logic [31:0] br;
		logic [31:0] bi;
		int          phase_pct [4];
		phase_pct    = '{0, 69, 0, 29};
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		quiet_cycles = 0;
		idle_pct     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		issue(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		issue(ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		issue(ACT_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
		issue(ACT_MUL, 32'h0001_8000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000);
		issue(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(ACT_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
		issue(ACT_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		issue(ACT_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
		issue(ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
		issue(ACT_DIV, 32'hFFFE_0000, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000);
		issue(ACT_POLAR, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 32'h0);
		issue(ACT_POLAR, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
		issue(ACT_POLAR, 32'hFFFF_0000, 32'h0000_0000, 32'h0, 32'h0);
		issue(ACT_POLAR, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0);
		issue(ACT_POLAR, 32'h0000_0000, 32'hFFFF_0000, 32'h0, 32'h0);
		issue(ACT_POLAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
		issue(ACT_POLAR, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		issue(ACT_POLAR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
		issue(3'd5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		issue(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			for (int n = 0; n < 225; n++) begin
				act = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				br  = pick_word();
				bi  = pick_word();
				if (act == ACT_DIV && $urandom_range(0, 9) == 0) begin
					br = '0;
					bi = '0;
				end
				issue(act, pick_word(), pick_word(), br, bi);
			end
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fails == 0)
			$display("complex_arithmetic_unit_core_tb OK");
		else
			$display("complex_arithmetic_unit_core_tb NOT OK");
		$finish;
	end

endmodule
